// ----- rtl/adaptive_altitude_velocity_control_defines.svh -----
// assertion macros used by the rtl controller
`ifndef ADAPTIVE_ALTITUDE_VELOCITY_CONTROL_DEFINES_SVH
`define ADAPTIVE_ALTITUDE_VELOCITY_CONTROL_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define AAVC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define AAVC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/aavc_pkg.sv -----
package aavc_pkg;

    localparam int E_W         = 21;
    localparam int VEL_W       = 18;
    localparam int VZ_W        = 17;
    localparam int COEF_W      = 32;
    localparam int LIM_W       = 16;
    localparam int W_W         = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 1;

    // shared multiplier datapath
    localparam int A_W     = 49;
    localparam int B_W     = 48;
    localparam int DIG_W   = 16;
    localparam int PROD_W  = A_W + DIG_W + 1;
    localparam int ACC_W   = 68;
    localparam int RES_W   = 50;
    localparam int DCNT_W  = 2;

    // rounded product widths
    localparam int KE_W  = 22;
    localparam int RE_W  = 38;
    localparam int REW_W = 37;
    localparam int REE_W = 42;
    localparam int DW_W  = A_W;
    localparam int INC_W = RES_W;
    localparam int U_W   = 39;

    localparam logic [COEF_W-1:0] GAIN_K_RST     = 32'h8000_0000;
    localparam logic [COEF_W-1:0] ADAPT_RATE_RST = 32'd4294967;
    localparam logic [COEF_W-1:0] LEAK_RATE_RST  = 32'd4294967;
    localparam logic [COEF_W-1:0] STEP_SIZE_RST  = 32'd4294967;
    localparam logic [LIM_W-1:0]  DRIVE_LIM_RST  = 16'd9830;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRUISE = 3'd0,
        REG_GAIN_K = 3'd1,
        REG_ADAPT  = 3'd2,
        REG_LEAK   = 3'd3,
        REG_STEP   = 3'd4,
        REG_LIMIT  = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_KE  = 3'd0,
        OP_RE  = 3'd1,
        OP_REW = 3'd2,
        OP_REE = 3'd3,
        OP_DW  = 3'd4,
        OP_INC = 3'd5
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_MAC   = 5'b00100,
        S_STORE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic capture;
        logic load;
        logic mac;
        logic last;
        logic store;
        logic emit;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic cruise;
    } t_status;

    // number of 16-bit multiplier digits per product
    function automatic logic [DCNT_W-1:0] op_digits(input t_op op);
        logic [DCNT_W-1:0] n;
        case (op)
            OP_REW, OP_DW, OP_INC: n = 2'd3;
            default:               n = 2'd2;
        endcase
        return n;
    endfunction

    function automatic t_op op_next(input t_op op);
        t_op n;
        case (op)
            OP_KE:   n = OP_RE;
            OP_RE:   n = OP_REW;
            OP_REW:  n = OP_REE;
            OP_REE:  n = OP_DW;
            OP_DW:   n = OP_INC;
            default: n = OP_KE;
        endcase
        return n;
    endfunction

    // half an lsb of the target format, preloaded into the accumulator
    function automatic logic [ACC_W-1:0] op_half(input t_op op);
        logic [ACC_W-1:0] h;
        case (op)
            OP_RE, OP_REE: h = ACC_W'(64'h0000_0000_0000_8000);
            OP_REW:        h = ACC_W'(64'h0000_8000_0000_0000);
            default:       h = ACC_W'(64'h0000_0000_8000_0000);
        endcase
        return h;
    endfunction

    // result taken one digit lower than the accumulator
    function automatic logic op_low_take(input t_op op);
        logic t;
        case (op)
            OP_KE, OP_REW: t = 1'b0;
            default:       t = 1'b1;
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/aavc_ctrl.sv -----
`include "adaptive_altitude_velocity_control_defines.svh"

module aavc_ctrl
    import aavc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    output logic    m_axis_tvalid,
    input  logic    m_axis_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [DCNT_W-1:0] r_dig, n_dig;
    logic              r_out_valid, n_out_valid;
    logic              w_in_acc;
    logic              w_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_last        = (r_dig == (op_digits(r_op) - 2'd1));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_dig       = r_dig;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    o_cmd.capture = 1'b1;
                    n_op          = OP_KE;
                    n_state       = i_status.cruise ? S_LOAD : S_EMIT;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_dig      = '0;
                n_state    = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac  = 1'b1;
                o_cmd.last = w_last;
                if (w_last) begin
                    n_state = S_STORE;
                end else begin
                    n_dig = r_dig + 2'd1;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_op == OP_INC) begin
                    n_state = S_EMIT;
                end else begin
                    n_op    = op_next(r_op);
                    n_state = S_LOAD;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_KE;
            r_dig       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_dig       <= n_dig;
            r_out_valid <= n_out_valid;
        end
    end

    `AAVC_ASSERT_IMP(a_mac_digit, r_state == S_MAC, r_dig < op_digits(r_op), "digit count past operand")
    `AAVC_ASSERT_IMP(a_first_op, (r_state == S_LOAD) && ($past(r_state) == S_IDLE), r_op == OP_KE, "item did not start with first product")
    `AAVC_ASSERT_NXT(a_inc_emit, (r_state == S_STORE) && (r_op == OP_INC), r_state == S_EMIT, "last product not followed by emit")
    `AAVC_ASSERT_NXT(a_emit_valid, o_cmd.emit, r_out_valid && (r_state == S_IDLE), "emitted item not presented")

endmodule

// ----- rtl/aavc_dp.sv -----
module aavc_dp
    import aavc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [IN_TDATA_W-1:0]  i_tdata,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic [OUT_TUSER_W-1:0] o_tuser
);

    // configuration
    logic              r_cruise;
    logic [COEF_W-1:0] r_gain_k;
    logic [COEF_W-1:0] r_adapt;
    logic [COEF_W-1:0] r_leak;
    logic [COEF_W-1:0] r_step;
    logic [LIM_W-1:0]  r_limit;

    // adaptive weight
    logic signed [W_W-1:0] r_w;

    // captured item
    logic signed [E_W-1:0]   r_e;
    logic [VEL_W-1:0]        r_vx;
    logic [VEL_W-1:0]        r_vy;

    // multiplier
    logic signed [A_W-1:0]    r_a;
    logic [B_W-1:0]           r_b;
    logic signed [ACC_W-1:0]  r_acc;
    logic [2*DIG_W-1:0]       r_low;
    logic signed [DIG_W:0]    w_digit;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [A_W-1:0]    w_a_ld;
    logic [B_W-1:0]           w_b_ld;
    logic [RES_W-1:0]         w_res;

    // rounded products
    logic signed [KE_W-1:0]  r_ke;
    logic signed [RE_W-1:0]  r_re;
    logic signed [REW_W-1:0] r_rew;
    logic signed [REE_W-1:0] r_ree;
    logic signed [DW_W-1:0]  r_dw;
    logic signed [INC_W-1:0] r_inc;
    logic signed [A_W-1:0]   w_diff;

    // result stage
    logic signed [U_W-1:0]   w_u;
    logic signed [U_W-1:0]   w_lim;
    logic signed [U_W-1:0]   w_nlim;
    logic [VZ_W-1:0]         w_vz;
    logic                    w_clip;
    logic signed [W_W+2:0]   w_wsum;
    logic [W_W-1:0]          w_wnext;
    logic [VEL_W-1:0]        r_vx_o;
    logic [VEL_W-1:0]        r_vy_o;
    logic [VZ_W-1:0]         r_vz_o;
    logic                    r_clip_o;

    assign o_status.cruise = r_cruise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise <= 1'b0;
            r_gain_k <= GAIN_K_RST;
            r_adapt  <= ADAPT_RATE_RST;
            r_leak   <= LEAK_RATE_RST;
            r_step   <= STEP_SIZE_RST;
            r_limit  <= DRIVE_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CRUISE: r_cruise <= i_cfg_data[0];
                REG_GAIN_K: r_gain_k <= i_cfg_data[COEF_W-1:0];
                REG_ADAPT:  r_adapt  <= i_cfg_data[COEF_W-1:0];
                REG_LEAK:   r_leak   <= i_cfg_data[COEF_W-1:0];
                REG_STEP:   r_step   <= i_cfg_data[COEF_W-1:0];
                REG_LIMIT:  r_limit  <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_e  <= i_tdata[E_W-1:0];
            r_vx <= i_tdata[E_W+VEL_W-1:E_W];
            r_vy <= i_tdata[E_W+2*VEL_W-1:E_W+VEL_W];
        end
    end

    assign w_diff = {{(A_W-REE_W){r_ree[REE_W-1]}}, r_ree} - r_dw;

    always_comb begin
        w_a_ld = '0;
        w_b_ld = '0;
        case (i_cmd.op)
            OP_KE: begin
                w_a_ld = {{(A_W-COEF_W){1'b0}}, r_gain_k};
                w_b_ld = {{(B_W-E_W){r_e[E_W-1]}}, r_e};
            end
            OP_RE: begin
                w_a_ld = {{(A_W-COEF_W){1'b0}}, r_adapt};
                w_b_ld = {{(B_W-E_W){r_e[E_W-1]}}, r_e};
            end
            OP_REW: begin
                w_a_ld = {{(A_W-RE_W){r_re[RE_W-1]}}, r_re};
                w_b_ld = r_w;
            end
            OP_REE: begin
                w_a_ld = {{(A_W-RE_W){r_re[RE_W-1]}}, r_re};
                w_b_ld = {{(B_W-E_W){r_e[E_W-1]}}, r_e};
            end
            OP_DW: begin
                w_a_ld = {{(A_W-COEF_W){1'b0}}, r_leak};
                w_b_ld = r_w;
            end
            OP_INC: begin
                w_a_ld = w_diff;
                w_b_ld = {{(B_W-COEF_W){1'b0}}, r_step};
            end
            default: begin
            end
        endcase
    end

    // top digit is signed, lower digits unsigned
    assign w_digit = {i_cmd.last ? r_b[DIG_W-1] : 1'b0, r_b[DIG_W-1:0]};
    assign w_prod  = r_a * w_digit;
    assign w_sum   = r_acc + {{(ACC_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= w_a_ld;
            r_b   <= w_b_ld;
            r_acc <= op_half(i_cmd.op);
        end else if (i_cmd.mac) begin
            r_acc <= w_sum >>> DIG_W;
            r_low <= {w_sum[DIG_W-1:0], r_low[2*DIG_W-1:DIG_W]};
            r_b   <= r_b >> DIG_W;
        end
    end

    assign w_res = op_low_take(i_cmd.op)
                 ? {r_acc[RES_W-DIG_W-1:0], r_low[2*DIG_W-1:DIG_W]}
                 : r_acc[RES_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            case (i_cmd.op)
                OP_KE:  r_ke  <= w_res[KE_W-1:0];
                OP_RE:  r_re  <= w_res[RE_W-1:0];
                OP_REW: r_rew <= w_res[REW_W-1:0];
                OP_REE: r_ree <= w_res[REE_W-1:0];
                OP_DW:  r_dw  <= w_res[DW_W-1:0];
                OP_INC: r_inc <= w_res[INC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // drive and clipping
    assign w_u    = -{{(U_W-KE_W){r_ke[KE_W-1]}}, r_ke}
                    - {{(U_W-REW_W){r_rew[REW_W-1]}}, r_rew};
    assign w_lim  = {{(U_W-LIM_W){1'b0}}, r_limit};
    assign w_nlim = -w_lim;

    always_comb begin
        if (w_u >= w_lim) begin
            w_vz   = w_lim[VZ_W-1:0];
            w_clip = 1'b1;
        end else if (w_u <= w_nlim) begin
            w_vz   = w_nlim[VZ_W-1:0];
            w_clip = 1'b1;
        end else begin
            w_vz   = w_u[VZ_W-1:0];
            w_clip = 1'b0;
        end
    end

    // weight update with saturation
    assign w_wsum = {{3{r_w[W_W-1]}}, r_w} + {{(W_W+3-INC_W){r_inc[INC_W-1]}}, r_inc};

    always_comb begin
        if (w_wsum[W_W+2:W_W-1] == {4{w_wsum[W_W-1]}}) begin
            w_wnext = w_wsum[W_W-1:0];
        end else if (w_wsum[W_W+2]) begin
            w_wnext = {1'b1, {(W_W-1){1'b0}}};
        end else begin
            w_wnext = {1'b0, {(W_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
        end else if (i_cmd.emit && r_cruise) begin
            r_w <= w_wnext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_cruise) begin
                r_vx_o   <= r_vx;
                r_vy_o   <= r_vy;
                r_vz_o   <= w_vz;
                r_clip_o <= w_clip;
            end else begin
                r_vx_o   <= '0;
                r_vy_o   <= '0;
                r_vz_o   <= '0;
                r_clip_o <= 1'b0;
            end
        end
    end

    assign o_tdata = {{(OUT_TDATA_W-2*VEL_W-VZ_W){1'b0}}, r_vz_o, r_vy_o, r_vx_o};
    assign o_tuser = r_clip_o;

endmodule

// ----- rtl/adaptive_altitude_velocity_control.sv -----
// Adaptive altitude drive with leakage on the weight, horizontal commands passed on.
// Input stream (s_axis): one item per sample, tdata carries height error,
// forward and side velocity commands. Output stream (m_axis): one item per
// input item, tdata carries the three velocities, tuser the clip flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
// clock edge; indexes past the drive limit register are ignored.
// Sequence: with cruise on, an item runs six rounded products through one
// shared 49x17 multiplier, 16 bits of one operand per cycle, each product
// in a load step, its digit steps and a store step; the result is then
// presented, and no new item is taken until it has been emitted. With
// cruise off the zero result is presented without the products, and the
// next item is likewise taken only after it has been emitted.
// The result sits in an output register; a new item is accepted while it
// waits, and if the receiver still stalls when the next result is ready the
// block holds that result and takes no further item until the slot frees.
// Reset (i_rst_n low, synchronous) clears the weight, loads the register
// defaults, empties the output register and returns the controller to idle.
module adaptive_altitude_velocity_control
    import aavc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // height_error, cmd_vel_x, cmd_vel_y
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // vel_x, vel_y, vel_z
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // drive_clipped
);

    t_cmd    w_cmd;
    t_status w_status;

    aavc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    aavc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tdata    (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser)
    );

endmodule
